>>> src/assert_macros.svh
// Assertion macros shared by the archive directory validator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ADV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ADV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/adv_pkg.sv
// Types, constants and helper functions of the archive directory validator.
package adv_pkg;

  // Sizes of the fixed parts of the file format.
  localparam int unsigned HDR_LEN   = 9;
  localparam int unsigned FIXED_LEN = 14;
  localparam int unsigned MIN_FILE  = HDR_LEN + FIXED_LEN + 2;
  localparam logic [31:0] SIZE_CAP  = 32'h4000_0000;

  // Defaults of the top level parameters.
  localparam int unsigned NAME_LIMIT_DEF   = 64;
  localparam int unsigned MEMBER_LIMIT_DEF = 262144;

  // Output buffer depth and packed result width.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned TDATA_W   = 216;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FIXED,
    PH_NAME,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic {
    KIND_MEMBER,
    KIND_SUMMARY
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_HEADER,
    ST_NO_MEMBERS,
    ST_NO_PAYLOAD,
    ST_BLOCK_BEYOND
  } status_e;

  // One result transaction as it leaves the block.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [17:0] member_index;
    logic [17:0] block_index;
    logic [29:0] slice_offset;
    logic [30:0] member_bytes;
    logic [31:0] record_position;
    logic [6:0]  name_bytes;
    logic [31:0] directory_end;
    logic [18:0] members_found;
    logic [18:0] blocks_found;
    logic        last;
  } res_t;

  // Parser output: a member record and a snapshot of the state for the summary.
  typedef struct packed {
    logic        mem_valid;
    logic        sum_valid;
    logic [17:0] member_index;
    logic [17:0] block_index;
    logic [29:0] slice_offset;
    logic [30:0] member_bytes;
    logic [31:0] record_position;
    logic [6:0]  name_bytes;
    logic        hdr_fail;
    logic        has_members;
    logic [32:0] total;
    logic [31:0] dir_end;
    logic [31:0] last_block;
    logic [18:0] members_found;
    logic [18:0] blocks_found;
  } mid_t;

  // Magic bytes at the start of the header.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h4C;
      2'd1:    val = 8'h54;
      2'd2:    val = 8'h45;
      default: val = 8'h43;
    endcase
    return val;
  endfunction

  // Printable name character that is not a path separator.
  function automatic logic name_char_ok(input logic [7:0] b);
    logic ok;
    ok = (b >= 8'h20) && (b <= 8'h7e) && (b != 8'h2f) && (b != 8'h5c) && (b != 8'h3a);
    return ok;
  endfunction

endpackage

>>> src/adv_parser.sv
// Byte parser: input register, directory walk state and the parser result register.
module adv_parser #(
  parameter int unsigned NAME_LIMIT   = adv_pkg::NAME_LIMIT_DEF,
  parameter int unsigned MEMBER_LIMIT = adv_pkg::MEMBER_LIMIT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output adv_pkg::mid_t mid_o
);

  localparam int unsigned FS_W = $clog2(NAME_LIMIT + adv_pkg::FIXED_LEN + 2);
  localparam int unsigned MT_W = $clog2(MEMBER_LIMIT + 1);
  localparam logic [15:0] LEN_MIN = 16'(adv_pkg::FIXED_LEN + 2);
  localparam logic [15:0] LEN_MAX = 16'(adv_pkg::FIXED_LEN + 1 + NAME_LIMIT);

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Walk state.
  adv_pkg::phase_e phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     rec_start_q, rec_start_d;
  logic [FS_W-1:0] fshift_q, fshift_d;
  logic [15:0]     rec_len_q, rec_len_d;
  logic [31:0]     blk_q, blk_d;
  logic [31:0]     slice_q, slice_d;
  logic [31:0]     size_q, size_d;
  logic            name_good_q, name_good_d;
  logic [31:0]     cur_blk_q, cur_blk_d;
  logic [30:0]     exp_slice_q, exp_slice_d;
  logic [MT_W-1:0] member_q, member_d;
  logic [MT_W-1:0] btotal_q, btotal_d;
  logic            hdr_good_q, hdr_good_d;
  logic [31:0]     pay_start_q, pay_start_d;

  adv_pkg::mid_t mid_q, mid_d;

  // Record checks on the fields gathered so far.
  logic        step;
  logic [1:0]  lane;
  logic [15:0] len_full;
  logic        name_last;
  logic        cb_valid;
  logic        new_blk;
  logic [32:0] span;
  logic        fields_ok;
  logic        accept;

  assign step     = en_i && in_valid_q;
  assign lane     = fshift_q[1:0] ^ 2'b10;
  assign len_full = {byte_q, rec_len_q[7:0]};
  assign name_last = (16'(fshift_q) + 16'd1) >= rec_len_q;
  assign cb_valid = (btotal_q != '0);
  assign new_blk  = !cb_valid || (blk_q != cur_blk_q);
  assign span     = {1'b0, slice_q} + {1'b0, size_q};

  always_comb begin
    fields_ok = (size_q != 32'd0) && (size_q <= adv_pkg::SIZE_CAP)
             && (span <= {1'b0, adv_pkg::SIZE_CAP})
             && (member_q < MT_W'(MEMBER_LIMIT));
    if (new_blk) begin
      fields_ok = fields_ok && (slice_q == 32'd0)
               && (cb_valid ? (blk_q > cur_blk_q) : (blk_q == 32'd0));
    end else begin
      fields_ok = fields_ok && (slice_q == {1'b0, exp_slice_q});
    end
  end

  assign accept = (phase_q == adv_pkg::PH_NAME) && name_last && (byte_q == 8'd0)
               && name_good_q && fields_ok;

  // Next state of the walk and the parser result.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q + 32'd1;
    rec_start_d = rec_start_q;
    fshift_d    = fshift_q;
    rec_len_d   = rec_len_q;
    blk_d       = blk_q;
    slice_d     = slice_q;
    size_d      = size_q;
    name_good_d = name_good_q;
    cur_blk_d   = cur_blk_q;
    exp_slice_d = exp_slice_q;
    member_d    = member_q;
    btotal_d    = btotal_q;
    hdr_good_d  = hdr_good_q;
    pay_start_d = pay_start_q;
    mid_d       = '0;

    case (phase_q)
      adv_pkg::PH_HEADER: begin
        if (pos_q < 32'd4 && byte_q != adv_pkg::magic_byte(pos_q[1:0])) begin
          hdr_good_d = 1'b0;
        end
        if (pos_q >= 32'(adv_pkg::HDR_LEN - 1)) begin
          if (byte_q != 8'd0) begin
            hdr_good_d = 1'b0;
          end
          if (hdr_good_d) begin
            phase_d     = adv_pkg::PH_FIXED;
            rec_start_d = 32'(adv_pkg::HDR_LEN);
            fshift_d    = '0;
          end else begin
            phase_d     = adv_pkg::PH_PAYLOAD;
            pay_start_d = 32'd0;
          end
        end
      end
      adv_pkg::PH_FIXED: begin
        // Each byte lands in its lane of the field it belongs to.
        if (fshift_q == FS_W'(0)) begin
          rec_len_d[7:0] = byte_q;
        end else if (fshift_q == FS_W'(1)) begin
          rec_len_d[15:8] = byte_q;
        end else if (fshift_q < FS_W'(6)) begin
          blk_d[{lane, 3'b000} +: 8] = byte_q;
        end else if (fshift_q < FS_W'(10)) begin
          slice_d[{lane, 3'b000} +: 8] = byte_q;
        end else begin
          size_d[{lane, 3'b000} +: 8] = byte_q;
        end
        fshift_d = fshift_q + FS_W'(1);
        if (fshift_q == FS_W'(1) && (len_full < LEN_MIN || len_full > LEN_MAX)) begin
          phase_d     = adv_pkg::PH_PAYLOAD;
          pay_start_d = rec_start_q;
        end else if (fshift_q == FS_W'(adv_pkg::FIXED_LEN - 1)) begin
          phase_d     = adv_pkg::PH_NAME;
          name_good_d = 1'b1;
        end
      end
      adv_pkg::PH_NAME: begin
        fshift_d = fshift_q + FS_W'(1);
        if (!name_last) begin
          if (!adv_pkg::name_char_ok(byte_q)) begin
            name_good_d = 1'b0;
          end
        end else if (accept) begin
          if (new_blk) begin
            cur_blk_d = blk_q;
            btotal_d  = btotal_q + MT_W'(1);
          end
          exp_slice_d = span[30:0];
          mid_d.mem_valid       = 1'b1;
          mid_d.member_index    = 18'(member_q);
          mid_d.block_index     = 18'(btotal_d - MT_W'(1));
          mid_d.slice_offset    = slice_q[29:0];
          mid_d.member_bytes    = size_q[30:0];
          mid_d.record_position = rec_start_q;
          mid_d.name_bytes      = 7'(rec_len_q - 16'd15);
          member_d    = member_q + MT_W'(1);
          rec_start_d = rec_start_q + {16'd0, rec_len_q};
          fshift_d    = '0;
          phase_d     = adv_pkg::PH_FIXED;
        end else begin
          phase_d     = adv_pkg::PH_PAYLOAD;
          pay_start_d = rec_start_q;
        end
      end
      default: begin
        // Payload bytes are only counted.
      end
    endcase

    // Snapshot for the summary, taken after this byte's update.
    mid_d.sum_valid     = last_q;
    mid_d.hdr_fail      = !hdr_good_d || (phase_d == adv_pkg::PH_HEADER);
    mid_d.has_members   = (member_d != '0) && (btotal_d != '0);
    mid_d.total         = {1'b0, pos_q} + 33'd1;
    mid_d.last_block    = cur_blk_d;
    mid_d.members_found = 19'(member_d);
    mid_d.blocks_found  = 19'(btotal_d);
    case (phase_d)
      adv_pkg::PH_HEADER:  mid_d.dir_end = 32'd0;
      adv_pkg::PH_PAYLOAD: mid_d.dir_end = pay_start_d;
      default:             mid_d.dir_end = rec_start_d;
    endcase

    // The last byte of a file returns the walk to its reset state.
    if (last_q) begin
      phase_d     = adv_pkg::PH_HEADER;
      pos_d       = 32'd0;
      rec_start_d = 32'(adv_pkg::HDR_LEN);
      fshift_d    = '0;
      rec_len_d   = 16'd0;
      name_good_d = 1'b1;
      exp_slice_d = 31'd0;
      member_d    = '0;
      btotal_d    = '0;
      hdr_good_d  = 1'b1;
      pay_start_d = 32'd0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en_i) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  // Walk state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= adv_pkg::PH_HEADER;
      pos_q       <= 32'd0;
      rec_start_q <= 32'(adv_pkg::HDR_LEN);
      fshift_q    <= '0;
      rec_len_q   <= 16'd0;
      name_good_q <= 1'b1;
      exp_slice_q <= 31'd0;
      member_q    <= '0;
      btotal_q    <= '0;
      hdr_good_q  <= 1'b1;
      pay_start_q <= 32'd0;
    end else if (step) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      rec_start_q <= rec_start_d;
      fshift_q    <= fshift_d;
      rec_len_q   <= rec_len_d;
      name_good_q <= name_good_d;
      exp_slice_q <= exp_slice_d;
      member_q    <= member_d;
      btotal_q    <= btotal_d;
      hdr_good_q  <= hdr_good_d;
      pay_start_q <= pay_start_d;
    end
  end

  // Record fields; they are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (step) begin
      blk_q     <= blk_d;
      slice_q   <= slice_d;
      size_q    <= size_d;
      cur_blk_q <= cur_blk_d;
    end
  end

  // Parser result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
    end else if (en_i) begin
      mid_q <= step ? mid_d : '0;
    end
  end

  assign mid_o = mid_q;

  `include "assert_macros.svh"

  `ADV_ASSERT_IMPL(a_header_early, clk_i, rst_ni, phase_q == adv_pkg::PH_HEADER,
                   pos_q < 32'(adv_pkg::HDR_LEN), "header phase past the header")
  `ADV_ASSERT(a_blocks_le_members, clk_i, rst_ni, btotal_q <= member_q,
              "more blocks than members")

endmodule

>>> src/adv_summary.sv
// Summary status and result assembly from the parser result register.
module adv_summary (
  input  logic          en_i,
  input  adv_pkg::mid_t mid_i,
  output logic [1:0]    wr_cnt_o,
  output adv_pkg::res_t ent0_o,
  output adv_pkg::res_t ent1_o
);

  adv_pkg::status_e status;
  adv_pkg::res_t    mem_res;
  adv_pkg::res_t    sum_res;
  logic [32:0]      dir_end_x;
  logic [32:0]      tail;

  assign dir_end_x = {1'b0, mid_i.dir_end};
  assign tail      = mid_i.total - dir_end_x;

  // Status in order of precedence.
  always_comb begin
    if (mid_i.total < 33'(adv_pkg::MIN_FILE) || mid_i.hdr_fail) begin
      status = adv_pkg::ST_BAD_HEADER;
    end else if (!mid_i.has_members) begin
      status = adv_pkg::ST_NO_MEMBERS;
    end else if (dir_end_x >= mid_i.total) begin
      status = adv_pkg::ST_NO_PAYLOAD;
    end else if ({1'b0, mid_i.last_block} >= tail) begin
      status = adv_pkg::ST_BLOCK_BEYOND;
    end else begin
      status = adv_pkg::ST_OK;
    end
  end

  // Member and summary results.
  always_comb begin
    mem_res                 = '0;
    mem_res.kind            = adv_pkg::KIND_MEMBER;
    mem_res.status          = adv_pkg::ST_OK;
    mem_res.member_index    = mid_i.member_index;
    mem_res.block_index     = mid_i.block_index;
    mem_res.slice_offset    = mid_i.slice_offset;
    mem_res.member_bytes    = mid_i.member_bytes;
    mem_res.record_position = mid_i.record_position;
    mem_res.name_bytes      = mid_i.name_bytes;
    mem_res.last            = !mid_i.sum_valid;

    sum_res               = '0;
    sum_res.kind          = adv_pkg::KIND_SUMMARY;
    sum_res.status        = status;
    sum_res.directory_end = mid_i.dir_end;
    sum_res.members_found = mid_i.members_found;
    sum_res.blocks_found  = mid_i.blocks_found;
    sum_res.last          = 1'b1;
  end

  // The member result goes first when a byte causes both.
  always_comb begin
    ent0_o = mid_i.mem_valid ? mem_res : sum_res;
    ent1_o = sum_res;
    if (!en_i) begin
      wr_cnt_o = 2'd0;
    end else begin
      wr_cnt_o = 2'(mid_i.mem_valid) + 2'(mid_i.sum_valid);
    end
  end

endmodule

>>> src/adv_out_fifo.sv
// Result buffer: takes up to two results a cycle and hands out one per transaction.
module adv_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    wr_cnt_i,
  input  adv_pkg::res_t ent0_i,
  input  adv_pkg::res_t ent1_i,
  input  logic          ready_i,
  output logic          valid_o,
  output adv_pkg::res_t data_o,
  output logic          room_o
);

  localparam int unsigned DEPTH = adv_pkg::OUT_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  adv_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] count_q;
  logic          pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  // Room for the two results that one byte may cause.
  assign room_o  = (count_q <= CW'(DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wp_q] <= ent0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wp_q + PW'(1)] <= ent1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + PW'(wr_cnt_i);
      rp_q    <= rp_q + PW'(pop);
      count_q <= count_q + CW'(wr_cnt_i) - CW'(pop);
    end
  end

  `include "assert_macros.svh"

  `ADV_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "buffer count overflow")
  `ADV_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, wr_cnt_i != 2'd0,
                   (count_q + CW'(wr_cnt_i)) <= CW'(DEPTH), "write into a full buffer")

endmodule

>>> src/archive_directory_validator.sv
// Top level of the archive directory validator.
//
//   channel  dir  handshake               payload
//   s_axis   in   tvalid/tready           tdata = data byte, tlast = end of file
//   m_axis   out  tvalid/tready           tdata = result fields, tuser = kind,
//                                         tlast = last result of the byte
//
// One byte is accepted every cycle while the result buffer holds two or fewer results.
// A byte passes the input register, the parser result register and the result
// buffer before its first result is visible.
// A byte that closes a record on the final byte of the file gives two results,
// which leave over two output transactions.
// Reset is asynchronous, active low, and takes effect at once; no clearing pass follows.
// A stall on m_axis fills the buffer and then holds s_axis_tready_o low.
module archive_directory_validator #(
  parameter int unsigned NAME_LIMIT   = adv_pkg::NAME_LIMIT_DEF,
  parameter int unsigned MEMBER_LIMIT = adv_pkg::MEMBER_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [7:0] data_byte
  input  logic [7:0]                  s_axis_tdata_i,
  // end_of_file
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [2:0] status, [20:3] member_index, [38:21] block_index, [68:39] slice_offset,
  // [99:69] member_bytes, [131:100] record_position, [138:132] name_bytes,
  // [170:139] directory_end, [189:171] members_found, [208:190] blocks_found,
  // [215:209] zero
  output logic [adv_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // result_kind
  output logic                        m_axis_tuser_o,
  // last_of_run
  output logic                        m_axis_tlast_o
);

  logic          room;
  adv_pkg::mid_t mid;
  logic [1:0]    wr_cnt;
  adv_pkg::res_t ent0;
  adv_pkg::res_t ent1;
  adv_pkg::res_t res;

  assign s_axis_tready_o = room;

  adv_parser #(
    .NAME_LIMIT  (NAME_LIMIT),
    .MEMBER_LIMIT(MEMBER_LIMIT)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (room),
    .in_valid_i(s_axis_tvalid_i),
    .in_byte_i (s_axis_tdata_i),
    .in_last_i (s_axis_tlast_i),
    .mid_o     (mid)
  );

  adv_summary u_summary (
    .en_i    (room),
    .mid_i   (mid),
    .wr_cnt_o(wr_cnt),
    .ent0_o  (ent0),
    .ent1_o  (ent1)
  );

  adv_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_cnt_i(wr_cnt),
    .ent0_i  (ent0),
    .ent1_i  (ent1),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .data_o  (res),
    .room_o  (room)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = {7'd0, res.blocks_found, res.members_found, res.directory_end,
                           res.name_bytes, res.record_position, res.member_bytes,
                           res.slice_offset, res.block_index, res.member_index,
                           res.status};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

>>> tb/tb_archive_directory_validator.sv
// Testbench of the archive directory validator: byte stream in, member and summary results out.
`timescale 1ns / 100ps

module tb_archive_directory_validator;
  import adv_pkg::*;

  // Header signature, first byte in the lowest bits.
  localparam logic [31:0] SIGNATURE = 32'h4345_544C;

  // One byte of the stimulus stream and whether the sender waits for an empty scoreboard.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       drain_first;
  } file_byte_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [7:0]          s_data = 8'h00;
  logic                s_last = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  file_byte_t  byte_stream[$];
  logic [7:0]  file_bytes[$];
  res_t        pending_results[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        in_taken = 1'b0;
  logic        quiet;

  // Shadow copy of the directory walker state.
  logic [31:0] arch_pos;
  phase_e      arch_phase;
  logic [31:0] rec_start;
  int unsigned fld_idx;
  logic [15:0] rec_len;
  logic [31:0] blk_seen;
  logic [31:0] slice_seen;
  logic [31:0] size_seen;
  logic        name_ok;
  logic [31:0] cur_blk;
  logic [31:0] next_slice;
  logic [18:0] members_cnt;
  logic [18:0] blocks_cnt;
  logic        hdr_ok;
  logic [31:0] payload_at;

  archive_directory_validator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Printable, and not a path separator or drive colon.
  function automatic logic name_byte_allowed(input logic [7:0] c);
    return (c >= 8'h20) && (c <= 8'h7E) && (c != "/") && (c != "\\") && (c != ":");
  endfunction

  function automatic logic [7:0] safe_name_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    while (!name_byte_allowed(c)) c = 8'($urandom_range(8'h20, 8'h7E));
    return c;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 94) return $urandom_range(1, 3);
    else return $urandom_range(10, 30);
  endfunction

  task automatic clear_walker();
    arch_pos = '0;
    arch_phase = PH_HEADER;
    rec_start = HDR_LEN;
    fld_idx = 0;
    rec_len = '0;
    blk_seen = '0;
    slice_seen = '0;
    size_seen = '0;
    name_ok = 1'b1;
    cur_blk = '0;
    next_slice = '0;
    members_cnt = '0;
    blocks_cnt = '0;
    hdr_ok = 1'b1;
    payload_at = '0;
  endtask

  // Advances the shadow walker by one byte and queues the results it causes.
  task automatic walk_archive_byte(input logic [7:0] b, input logic eof);
    logic [31:0] at;
    logic [31:0] name_size;
    logic [31:0] name_last;
    logic [18:0] blk_num;
    logic [32:0] total;
    logic [32:0] dir_end;
    logic        fresh_block;
    logic        fields_ok;
    int unsigned k;
    status_e     st;
    res_t        r;
    at = arch_pos;
    k = fld_idx;
    case (arch_phase)
      PH_HEADER: begin
        if (at < 4 && b != SIGNATURE[8*at[1:0] +: 8]) hdr_ok = 1'b0;
        if (at >= HDR_LEN - 1) begin
          if (b != 8'h00) hdr_ok = 1'b0;
          if (hdr_ok) begin
            arch_phase = PH_FIXED;
            rec_start = HDR_LEN;
            fld_idx = 0;
          end else begin
            arch_phase = PH_PAYLOAD;
            payload_at = '0;
          end
        end
      end
      PH_FIXED: begin
        // Fixed fields arrive little-endian, one byte lane at a time.
        if (k == 0) rec_len = {8'h00, b};
        else if (k == 1) rec_len[15:8] = b;
        else if (k < 6) blk_seen[8*(k-2) +: 8] = b;
        else if (k < 10) slice_seen[8*(k-6) +: 8] = b;
        else size_seen[8*(k-10) +: 8] = b;
        fld_idx = k + 1;
        if (k == 1 && (rec_len < FIXED_LEN + 2 || rec_len > FIXED_LEN + 1 + NAME_LIMIT_DEF)) begin
          arch_phase = PH_PAYLOAD;
          payload_at = rec_start;
        end else if (fld_idx == FIXED_LEN) begin
          arch_phase = PH_NAME;
          name_ok = 1'b1;
        end
      end
      PH_NAME: begin
        name_size = rec_len - FIXED_LEN;
        fld_idx = k + 1;
        if (k - FIXED_LEN + 1 < name_size) begin
          if (!name_byte_allowed(b)) name_ok = 1'b0;
        end else begin
          // Terminator byte: decide on the whole record.
          fresh_block = (blocks_cnt == 0) || (blk_seen != cur_blk);
          fields_ok = (size_seen != 0) && (size_seen <= SIZE_CAP) &&
                      (slice_seen <= SIZE_CAP - size_seen);
          if (fresh_block) begin
            if (blocks_cnt != 0 && blk_seen < cur_blk) fields_ok = 1'b0;
            if (slice_seen != 0) fields_ok = 1'b0;
            if (blocks_cnt == 0 && blk_seen != 0) fields_ok = 1'b0;
          end else if (slice_seen != next_slice) begin
            fields_ok = 1'b0;
          end
          if (members_cnt >= MEMBER_LIMIT_DEF) fields_ok = 1'b0;
          if (b == 8'h00 && name_ok && fields_ok) begin
            if (fresh_block) begin
              cur_blk = blk_seen;
              blocks_cnt = blocks_cnt + 19'd1;
            end
            next_slice = slice_seen + size_seen;
            blk_num = blocks_cnt - 19'd1;
            name_last = name_size - 1;
            r = '0;
            r.kind = KIND_MEMBER;
            r.status = ST_OK;
            r.member_index = members_cnt[17:0];
            r.block_index = blk_num[17:0];
            r.slice_offset = slice_seen[29:0];
            r.member_bytes = size_seen[30:0];
            r.record_position = rec_start;
            r.name_bytes = name_last[6:0];
            r.last = ~eof;
            pending_results.push_back(r);
            members_cnt = members_cnt + 19'd1;
            rec_start = rec_start + rec_len;
            fld_idx = 0;
            arch_phase = PH_FIXED;
          end else begin
            arch_phase = PH_PAYLOAD;
            payload_at = rec_start;
          end
        end
      end
      default: ;
    endcase
    arch_pos = at + 1;

    if (eof) begin
      total = {1'b0, at} + 33'd1;
      if (arch_phase == PH_HEADER) dir_end = '0;
      else if (arch_phase == PH_PAYLOAD) dir_end = {1'b0, payload_at};
      else dir_end = {1'b0, rec_start};
      if (total < MIN_FILE || !hdr_ok || arch_phase == PH_HEADER) st = ST_BAD_HEADER;
      else if (members_cnt == 0 || blocks_cnt == 0) st = ST_NO_MEMBERS;
      else if (dir_end >= total) st = ST_NO_PAYLOAD;
      else if ({1'b0, cur_blk} >= total - dir_end) st = ST_BLOCK_BEYOND;
      else st = ST_OK;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.status = st;
      r.directory_end = dir_end[31:0];
      r.members_found = members_cnt;
      r.blocks_found = blocks_cnt;
      r.last = 1'b1;
      pending_results.push_back(r);
      clear_walker();
    end
  endtask

  task automatic check_field(input string fname, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  // File builder: header, records, payload, then hand the bytes to the sender.
  task automatic start_file(input bit magic_ok, input bit pad_ok);
    int unsigned idx;
    logic [7:0]  flip;
    file_bytes.delete();
    for (int i = 0; i < 4; i++) file_bytes.push_back(SIGNATURE[8*i +: 8]);
    if (!magic_ok) begin
      idx = $urandom_range(0, 3);
      flip = 8'($urandom_range(1, 255));
      file_bytes[idx] = file_bytes[idx] ^ flip;
    end
    repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
    flip = 8'($urandom_range(1, 255));
    file_bytes.push_back(pad_ok ? 8'h00 : flip);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic add_record(input logic [15:0] len_field, input logic [31:0] blk,
                            input logic [31:0] slice, input logic [31:0] size,
                            input int name_len, input int bad_at, input logic [7:0] bad_char,
                            input bit no_nul);
    file_bytes.push_back(len_field[7:0]);
    file_bytes.push_back(len_field[15:8]);
    put_word(blk);
    put_word(slice);
    put_word(size);
    for (int j = 0; j < name_len; j++)
      file_bytes.push_back((j == bad_at) ? bad_char : safe_name_char());
    file_bytes.push_back(no_nul ? safe_name_char() : 8'h00);
  endtask

  task automatic add_payload(input int unsigned n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Queues the first keep bytes of the file (all of them for zero), last one marked end of file.
  task automatic emit_file(input int unsigned keep, input bit drain);
    int unsigned n;
    file_byte_t  fb;
    n = (keep == 0 || keep > file_bytes.size()) ? file_bytes.size() : keep;
    for (int unsigned j = 0; j < n; j++) begin
      fb.data = file_bytes[j];
      fb.eof = (j == n - 1);
      fb.drain_first = drain && (j == 0);
      byte_stream.push_back(fb);
    end
    bytes_queued = bytes_queued + n;
  endtask

  // Mostly well-formed directories with random content; some noise and broken records.
  task automatic random_file();
    int unsigned pick;
    int unsigned n_rec;
    int unsigned bad_rec;
    int unsigned keep;
    int          name_len;
    int          bad_at;
    logic [15:0] len_field;
    logic [31:0] blk;
    logic [31:0] slice;
    logic [31:0] size;
    logic [31:0] w_blk;
    logic [31:0] w_slice;
    logic [31:0] w_size;
    logic [7:0]  bad_char;
    bit          no_nul;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if (pick < 5) start_file(1'b1, 1'b1);
      else file_bytes.delete();
      add_payload($urandom_range(1, 40));
      emit_file(0, 1'b0);
    end else begin
      start_file(pick >= 13, pick < 13 || pick >= 15);
      n_rec = $urandom_range(1, 6);
      bad_rec = ($urandom_range(0, 99) < 30) ? $urandom_range(0, n_rec - 1) : n_rec;
      blk = '0;
      slice = '0;
      for (int unsigned i = 0; i < n_rec; i++) begin
        // Members tile their block; a new block starts at slice zero.
        if (i != 0 && (slice > SIZE_CAP - 4096 || $urandom_range(0, 2) == 0)) begin
          blk = blk + $urandom_range(1, 8);
          slice = '0;
        end
        size = ($urandom_range(0, 15) == 0) ? SIZE_CAP - slice : $urandom_range(1, 4000);
        pick = $urandom_range(0, 9);
        name_len = (pick == 0) ? 1 : (pick == 1) ? NAME_LIMIT_DEF : $urandom_range(1, 12);
        len_field = 16'(name_len + FIXED_LEN + 1);
        w_blk = blk;
        w_slice = slice;
        w_size = size;
        bad_at = -1;
        bad_char = 8'h00;
        no_nul = 1'b0;
        if (i == bad_rec) begin
          case ($urandom_range(0, 8))
            0: len_field = 16'($urandom_range(0, FIXED_LEN + 1));
            1: len_field = 16'($urandom_range(FIXED_LEN + 2 + NAME_LIMIT_DEF, 16'hFFFF));
            2: begin
              bad_at = $urandom_range(0, name_len - 1);
              case ($urandom_range(0, 4))
                0: bad_char = "/";
                1: bad_char = "\\";
                2: bad_char = ":";
                3: bad_char = 8'($urandom_range(8'h00, 8'h1F));
                default: bad_char = 8'($urandom_range(8'h7F, 8'hFF));
              endcase
            end
            3: no_nul = 1'b1;
            4: w_size = '0;
            5: w_size = SIZE_CAP - slice + $urandom_range(1, 64);
            6: w_slice = slice + $urandom_range(1, 64);
            7: w_blk = $urandom;
            default: w_blk = blk - 1;
          endcase
        end
        add_record(len_field, w_blk, w_slice, w_size, name_len, bad_at, bad_char, no_nul);
        slice = slice + size;
      end
      add_payload(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40));
      keep = ($urandom_range(0, 11) == 0) ? $urandom_range(1, file_bytes.size()) : 0;
      emit_file(keep, $urandom_range(0, 29) == 0);
    end
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both sides run without idling while bits 10:8 of the cycle count are zero.
  assign quiet = (cycle_count[10:8] == 3'd0);

  // Sender: presents the next queued byte, holding it until the transaction completes.
  always @(negedge clk_i) begin : send_bytes
    file_byte_t item;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_valid <= 1'b0;
      end else if (byte_stream.size() != 0 &&
                   !(byte_stream[0].drain_first && pending_results.size() != 0)) begin
        item = byte_stream.pop_front();
        s_valid <= 1'b1;
        s_data <= item.data;
        s_last <= item.eof;
        gap_left <= quiet ? 0 : pick_idle();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure on the result stream.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      stall_left <= quiet ? 0 : pick_idle();
    end
  end

  // Monitor: predict on each byte transaction, check each result transaction.
  always @(posedge clk_i) begin : watch_bus
    res_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_valid && s_ready;
      if (s_valid && s_ready) walk_archive_byte(s_data, s_last);
      if (m_valid && m_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no result expected");
          mismatches = mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.kind, m_tuser);
          check_field("status", want.status, m_tdata[2:0]);
          check_field("member_index", want.member_index, m_tdata[20:3]);
          check_field("block_index", want.block_index, m_tdata[38:21]);
          check_field("slice_offset", want.slice_offset, m_tdata[68:39]);
          check_field("member_bytes", want.member_bytes, m_tdata[99:69]);
          check_field("record_position", want.record_position, m_tdata[131:100]);
          check_field("name_bytes", want.name_bytes, m_tdata[138:132]);
          check_field("directory_end", want.directory_end, m_tdata[170:139]);
          check_field("members_found", want.members_found, m_tdata[189:171]);
          check_field("blocks_found", want.blocks_found, m_tdata[208:190]);
          check_field("last_of_run", want.last, m_tlast);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [7:0]  bad_c;
    clear_walker();

    // Smallest good file: one member, one payload byte.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 1, 1, -1, 8'h00, 1'b0);
    add_payload(1);
    emit_file(0, 1'b0);
    // Broken signature, then a nonzero last header byte.
    start_file(1'b0, 1'b1);
    add_payload(20);
    emit_file(0, 1'b0);
    start_file(1'b1, 1'b0);
    add_payload(20);
    emit_file(0, 1'b0);
    // One-byte file, file cut inside the header, good header but file too short.
    start_file(1'b1, 1'b1);
    emit_file(1, 1'b0);
    start_file(1'b1, 1'b1);
    emit_file(5, 1'b0);
    start_file(1'b1, 1'b1);
    add_payload(11);
    emit_file(0, 1'b0);
    // Record lengths just outside the allowed range.
    start_file(1'b1, 1'b1);
    add_record(16'(FIXED_LEN + 1), 0, 0, 1, 0, -1, 8'h00, 1'b0);
    add_payload(5);
    emit_file(0, 1'b0);
    start_file(1'b1, 1'b1);
    add_record(16'(FIXED_LEN + 2 + NAME_LIMIT_DEF), 0, 0, 1, 10, -1, 8'h00, 1'b0);
    add_payload(5);
    emit_file(0, 1'b0);
    // Longest name, two members tiling block 0 up to the cap, then a full block 5.
    start_file(1'b1, 1'b1);
    add_record(16'(NAME_LIMIT_DEF + 15), 0, 0, 100, NAME_LIMIT_DEF, -1, 8'h00, 1'b0);
    add_record(16, 0, 100, SIZE_CAP - 100, 1, -1, 8'h00, 1'b0);
    add_record(20, 5, 0, SIZE_CAP, 5, -1, 8'h00, 1'b0);
    add_payload(30);
    emit_file(0, 1'b0);
    // Each forbidden name character in a second record.
    for (int c = 0; c < 5; c++) begin
      case (c)
        0: bad_c = "/";
        1: bad_c = "\\";
        2: bad_c = ":";
        3: bad_c = 8'h1F;
        default: bad_c = 8'h7F;
      endcase
      start_file(1'b1, 1'b1);
      add_record(18, 0, 0, 7, 3, -1, 8'h00, 1'b0);
      add_record(18, 0, 7, 9, 3, 1, bad_c, 1'b0);
      add_payload(8);
      emit_file(0, 1'b0);
    end
    // Name field without its terminator.
    start_file(1'b1, 1'b1);
    add_record(18, 0, 0, 7, 3, -1, 8'h00, 1'b1);
    add_payload(4);
    emit_file(0, 1'b0);
    // Zero member size.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 0, 1, -1, 8'h00, 1'b0);
    add_payload(4);
    emit_file(0, 1'b0);
    // Member running past the block plaintext limit.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, SIZE_CAP, 1, -1, 8'h00, 1'b0);
    add_record(16, 0, SIZE_CAP, 1, 1, -1, 8'h00, 1'b0);
    add_payload(4);
    emit_file(0, 1'b0);
    // New block that does not start at slice zero.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    add_record(16, 3, 2, 10, 1, -1, 8'h00, 1'b0);
    add_payload(4);
    emit_file(0, 1'b0);
    // First block not at offset zero.
    start_file(1'b1, 1'b1);
    add_record(16, 7, 0, 10, 1, -1, 8'h00, 1'b0);
    add_payload(10);
    emit_file(0, 1'b0);
    // Block offset going backwards.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    add_record(16, 10, 0, 10, 1, -1, 8'h00, 1'b0);
    add_record(16, 5, 0, 10, 1, -1, 8'h00, 1'b0);
    add_payload(20);
    emit_file(0, 1'b0);
    // Gap between two members of one block.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    add_record(16, 0, 11, 5, 1, -1, 8'h00, 1'b0);
    add_payload(4);
    emit_file(0, 1'b0);
    // Directory running to the end of file: member and summary on one byte.
    // The sender first lets every outstanding result drain.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    emit_file(0, 1'b1);
    // Last block offset beyond the payload.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    add_record(16, 50, 0, 10, 1, -1, 8'h00, 1'b0);
    add_payload(10);
    emit_file(0, 1'b0);
    // Record cut by end of file, once inside the fields and once on its first byte.
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    add_record(16, 0, 10, 10, 1, -1, 8'h00, 1'b0);
    emit_file(HDR_LEN + 16 + 7, 1'b0);
    start_file(1'b1, 1'b1);
    add_record(16, 0, 0, 10, 1, -1, 8'h00, 1'b0);
    add_payload(4);
    emit_file(HDR_LEN + 16 + 1, 1'b0);
    // All ones and all zeros after a good header.
    start_file(1'b1, 1'b1);
    repeat (20) file_bytes.push_back(8'hFF);
    emit_file(0, 1'b0);
    start_file(1'b1, 1'b1);
    repeat (20) file_bytes.push_back(8'h00);
    emit_file(0, 1'b0);

    // Random files fill the stream up to its planned length.
    while (bytes_queued < 1900) random_file();

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_stream.size() != 0 || s_valid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit on run length.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
